// ===== rtl/core/scab_pkg.sv =====
package scab_pkg;

   // Coordinate bits taken from the pixel position fields
   localparam int COORD_BITS = 12;
   localparam int PIX_BITS   = 12;
   localparam logic [PIX_BITS-1:0] PIX_MASK = PIX_BITS'((64'd1 << COORD_BITS) - 64'd1);

   // Configuration register indexes
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SHAPE_MODE  = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ORIGIN_X    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ORIGIN_Y    = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EXTENT_W    = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EXTENT_H    = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STROKE      = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DRAW_COLOR  = 3'd6;

   // Shape modes
   localparam logic [1:0] MODE_RECT_FILL    = 2'd0;
   localparam logic [1:0] MODE_RECT_OUTLINE = 2'd1;
   localparam logic [1:0] MODE_CIRCLE_FILL  = 2'd2;
   localparam logic [1:0] MODE_CIRCLE_RING  = 2'd3;

   typedef logic signed [15:0] edge_type;
   typedef logic signed [29:0] dist_type;

   // Floor of n / 255, exact for n below 255 * 256
   function automatic logic [7:0] div255(input logic [15:0] n);
      logic [16:0] sum;
      begin
         sum = 17'(n) + 17'(n[15:8]) + 17'd1;
         return sum[15:8];
      end
   endfunction

endpackage

// ===== rtl/core/shape_coverage_alpha_blend.sv =====
// Shape coverage test and source-over blend, one pixel per transaction.
// Registered stages from input acceptance to result valid: subtract, square and
// box compare, distance compare and blend products, blend divide and select. Throughput: one
// transaction per cycle with rsp_ready high; stages advance alone, so bubbles close up.
// Reset (synchronous, active high) clears all valid bits and loads the register defaults.
// Shape-derived edges and radius thresholds are registered from the configuration registers.
module shape_coverage_alpha_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   input  logic [31:0] req_dest_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_out,
   output logic        rsp_covered
);

   // ---------------- configuration registers ----------------
   logic [1:0]         shape_mode_ff;
   logic signed [12:0] origin_x_ff, origin_y_ff, extent_w_ff, extent_h_ff;
   logic [11:0]        stroke_ff;
   logic [31:0]        draw_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_mode_ff <= scab_pkg::MODE_RECT_FILL;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         extent_w_ff   <= '0;
         extent_h_ff   <= '0;
         stroke_ff     <= 12'd1;
         draw_color_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            scab_pkg::CSR_SHAPE_MODE: shape_mode_ff <= csr_wdata[1:0];
            scab_pkg::CSR_ORIGIN_X:   origin_x_ff   <= signed'(csr_wdata[12:0]);
            scab_pkg::CSR_ORIGIN_Y:   origin_y_ff   <= signed'(csr_wdata[12:0]);
            scab_pkg::CSR_EXTENT_W:   extent_w_ff   <= signed'(csr_wdata[12:0]);
            scab_pkg::CSR_EXTENT_H:   extent_h_ff   <= signed'(csr_wdata[12:0]);
            scab_pkg::CSR_STROKE:     stroke_ff     <= csr_wdata[11:0];
            scab_pkg::CSR_DRAW_COLOR: draw_color_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- shape-derived values (registered from config) ----------------
   scab_pkg::edge_type left_in, right_in, top_in, bot_in;
   scab_pkg::edge_type ileft_in, iright_in, itop_in, ibot_in;
   scab_pkg::edge_type ox, oy, ew, eh, th, wabs, habs;
   logic               rect_ok_in, inner_ok_in;
   logic signed [25:0] rsq;
   logic signed [13:0] rmt;
   logic signed [27:0] rmtsq;
   scab_pkg::dist_type hi_in, lo_in;

   scab_pkg::edge_type left_ff, right_ff, top_ff, bot_ff;
   scab_pkg::edge_type ileft_ff, iright_ff, itop_ff, ibot_ff;
   logic               rect_ok_ff, inner_ok_ff;
   scab_pkg::dist_type hi_ff, lo_ff;

   always_comb begin
      ox   = 16'(origin_x_ff);
      oy   = 16'(origin_y_ff);
      ew   = 16'(extent_w_ff);
      eh   = 16'(extent_h_ff);
      th   = signed'({4'd0, stroke_ff});
      wabs = extent_w_ff[12] ? -ew : ew;
      habs = extent_h_ff[12] ? -eh : eh;
      // Normalize negative extents
      left_in  = extent_w_ff[12] ? ox + ew : ox;
      right_in = extent_w_ff[12] ? ox : ox + ew;
      top_in   = extent_h_ff[12] ? oy + eh : oy;
      bot_in   = extent_h_ff[12] ? oy : oy + eh;
      ileft_in  = left_in + th;
      iright_in = right_in - th;
      itop_in   = top_in + th;
      ibot_in   = bot_in - th;
      rect_ok_in  = (wabs != 16'sd0) && (habs != 16'sd0);
      inner_ok_in = (wabs > (th <<< 1)) && (habs > (th <<< 1));
      // Circle thresholds: r*r + r and (r-t)^2 + r
      rsq   = 26'(extent_w_ff) * 26'(extent_w_ff);
      rmt   = 14'(extent_w_ff) - signed'({2'd0, stroke_ff});
      rmtsq = 28'(rmt) * 28'(rmt);
      hi_in = 30'(rsq) + 30'(extent_w_ff);
      lo_in = 30'(rmtsq) + 30'(extent_w_ff);
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      ileft_ff    <= ileft_in;
      iright_ff   <= iright_in;
      itop_ff     <= itop_in;
      ibot_ff     <= ibot_in;
      rect_ok_ff  <= rect_ok_in;
      inner_ok_ff <= inner_ok_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
   end

   // ---------------- stage handshake ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: offsets from the circle center ----------------
   logic [11:0]        pxm, pym;
   scab_pkg::edge_type px1_in, py1_in;
   logic signed [14:0] dx1_in, dy1_in;

   scab_pkg::edge_type px1_ff, py1_ff;
   logic signed [14:0] dx1_ff, dy1_ff;
   logic [31:0]        dest1_ff;

   always_comb begin
      pxm    = req_pixel_x & scab_pkg::PIX_MASK;
      pym    = req_pixel_y & scab_pkg::PIX_MASK;
      px1_in = signed'({4'd0, pxm});
      py1_in = signed'({4'd0, pym});
      dx1_in = signed'({3'd0, pxm}) - 15'(origin_x_ff);
      dy1_in = signed'({3'd0, pym}) - 15'(origin_y_ff);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         px1_ff   <= px1_in;
         py1_ff   <= py1_in;
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         dest1_ff <= req_dest_pixel;
      end
   end

   // ---------------- stage 2: squares and box tests ----------------
   scab_pkg::dist_type dx2_ff, dy2_ff;
   logic               outer_in_ff, inner_in_ff;
   logic [31:0]        dest2_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         dx2_ff      <= 30'(dx1_ff) * 30'(dx1_ff);
         dy2_ff      <= 30'(dy1_ff) * 30'(dy1_ff);
         outer_in_ff <= rect_ok_ff && (px1_ff >= left_ff) && (px1_ff < right_ff)
                        && (py1_ff >= top_ff) && (py1_ff < bot_ff);
         inner_in_ff <= inner_ok_ff && (px1_ff >= ileft_ff) && (px1_ff < iright_ff)
                        && (py1_ff >= itop_ff) && (py1_ff < ibot_ff);
         dest2_ff    <= dest1_ff;
      end
   end

   // ---------------- stage 3: coverage decision and blend products ----------------
   scab_pkg::dist_type d2;
   logic               cov3_in;
   logic [7:0]         sa, sa_inv;
   logic [15:0]        ps_in [4];
   logic [15:0]        pd_in [4];

   always_comb begin
      d2 = dx2_ff + dy2_ff;
      case (shape_mode_ff)
         scab_pkg::MODE_RECT_FILL:    cov3_in = outer_in_ff;
         scab_pkg::MODE_RECT_OUTLINE: cov3_in = (stroke_ff != 12'd0) && outer_in_ff
                                                && !inner_in_ff;
         scab_pkg::MODE_CIRCLE_FILL:  cov3_in = !extent_w_ff[12] && (d2 <= hi_ff);
         scab_pkg::MODE_CIRCLE_RING:  cov3_in = !extent_w_ff[12] && (d2 <= hi_ff)
                                                && (d2 >= lo_ff);
         default:                     cov3_in = 1'b0;
      endcase
      sa     = draw_color_ff[31:24];
      sa_inv = 8'd255 - sa;
      // Color channels in bytes 0..2, alpha in byte 3 with a full-scale source
      for (int k = 0; k < 4; k++) begin
         pd_in[k] = 16'(dest2_ff[8*k +: 8]) * 16'(sa_inv);
      end
      for (int k = 0; k < 3; k++) begin
         ps_in[k] = 16'(draw_color_ff[8*k +: 8]) * 16'(sa);
      end
      ps_in[3] = 16'(sa) * 16'd255;
   end

   logic [15:0] ps3_ff [4];
   logic [15:0] pd3_ff [4];
   logic        cov3_ff;
   logic [31:0] dest3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         ps3_ff   <= ps_in;
         pd3_ff   <= pd_in;
         cov3_ff  <= cov3_in;
         dest3_ff <= dest2_ff;
      end
   end

   // ---------------- stage 4: divide by 255 and select ----------------
   logic [31:0] blend_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         blend_in[8*k +: 8] = scab_pkg::div255(ps3_ff[k] + pd3_ff[k]);
      end
   end

   logic [31:0] pix4_ff;
   logic        cov4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         pix4_ff <= cov3_ff ? blend_in : dest3_ff;
         cov4_ff <= cov3_ff;
      end
   end

   assign rsp_valid     = v4_ff;
   assign rsp_pixel_out = pix4_ff;
   assign rsp_covered   = cov4_ff;

endmodule

// ===== sim/shape_coverage_alpha_blend_check.sv =====
// Scoreboard for the shape coverage blender: tracks the register writes,
// predicts every accepted pixel and compares the returned pixels in order.
module shape_coverage_alpha_blend_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   input  logic [31:0] req_dest_pixel,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_pixel_out,
   input  logic        rsp_covered,
   output int          mismatches,
   output int          pending,
   output int          pixels_checked,
   output int          pixels_covered
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] pixel;
      logic        covered;
   } blended_pixel_type;

   // Shadow copy of the shape registers
   logic [1:0]  shape_mode;
   longint      org_x, org_y, ext_w, ext_h, stroke;
   logic [31:0] ink;

   blended_pixel_type expected_pixels[$];
   blended_pixel_type oldest;

   function automatic bit in_box(longint px, longint py, longint x, longint y,
                                 longint w, longint h);
      if (w <= 0 || h <= 0) return 0;
      return px >= x && px < x + w && py >= y && py < y + h;
   endfunction

   function automatic bit shape_hits(longint px, longint py);
      longint x, y, w, h, d2, rim;
      x  = org_x;
      y  = org_y;
      w  = ext_w;
      h  = ext_h;
      d2 = (px - org_x) * (px - org_x) + (py - org_y) * (py - org_y);
      if (shape_mode == scab_pkg::MODE_RECT_FILL ||
          shape_mode == scab_pkg::MODE_RECT_OUTLINE) begin
         // negative extents flip the rectangle back over its origin
         if (w < 0) begin
            x = x + w;
            w = -w;
         end
         if (h < 0) begin
            y = y + h;
            h = -h;
         end
         if (shape_mode == scab_pkg::MODE_RECT_FILL) return in_box(px, py, x, y, w, h);
         if (stroke <= 0) return 0;
         if (!in_box(px, py, x, y, w, h)) return 0;
         return !in_box(px, py, x + stroke, y + stroke, w - 2 * stroke, h - 2 * stroke);
      end
      if (ext_w < 0) return 0;
      rim = ext_w * ext_w + ext_w;
      if (shape_mode == scab_pkg::MODE_CIRCLE_FILL) return d2 <= rim;
      return d2 >= (ext_w - stroke) * (ext_w - stroke) + ext_w && d2 <= rim;
   endfunction

   // Source-over of the drawing color onto the destination pixel
   function automatic logic [31:0] over_blend(logic [31:0] dst, logic [31:0] src);
      int unsigned a, s, d;
      logic [31:0] res;
      a = src[31:24];
      if (a == 255) return src;
      if (a == 0) return dst;
      for (int k = 0; k < 3; k++) begin
         s = src[8*k +: 8];
         d = dst[8*k +: 8];
         res[8*k +: 8] = 8'((s * a + d * (255 - a)) / 255);
      end
      d = dst[31:24];
      res[31:24] = 8'((a * 255 + d * (255 - a)) / 255);
      return res;
   endfunction

   function automatic blended_pixel_type predict_pixel(logic [11:0] x, logic [11:0] y,
                                                       logic [31:0] dst);
      blended_pixel_type r;
      longint px, py;
      px = x & scab_pkg::PIX_MASK;
      py = y & scab_pkg::PIX_MASK;
      r.covered = shape_hits(px, py);
      r.pixel   = r.covered ? over_blend(dst, ink) : dst;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shape_mode = scab_pkg::MODE_RECT_FILL;
         org_x      = 0;
         org_y      = 0;
         ext_w      = 0;
         ext_h      = 0;
         stroke     = 1;
         ink        = 32'h0;
         expected_pixels.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               scab_pkg::CSR_SHAPE_MODE: shape_mode = csr_wdata[1:0];
               scab_pkg::CSR_ORIGIN_X:   org_x      = $signed(csr_wdata[12:0]);
               scab_pkg::CSR_ORIGIN_Y:   org_y      = $signed(csr_wdata[12:0]);
               scab_pkg::CSR_EXTENT_W:   ext_w      = $signed(csr_wdata[12:0]);
               scab_pkg::CSR_EXTENT_H:   ext_h      = $signed(csr_wdata[12:0]);
               scab_pkg::CSR_STROKE:     stroke     = csr_wdata[11:0];
               scab_pkg::CSR_DRAW_COLOR: ink        = csr_wdata;
               default: ;
            endcase
         end
         // input transaction
         if (req_valid && req_ready)
            expected_pixels.push_back(predict_pixel(req_pixel_x, req_pixel_y, req_dest_pixel));
         // result transaction
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result pixel_out=%h covered=%b",
                        $time, rsp_pixel_out, rsp_covered);
               mismatches++;
            end else begin
               oldest = expected_pixels.pop_front();
               pixels_checked++;
               if (oldest.covered) pixels_covered++;
               if (rsp_pixel_out !== oldest.pixel) begin
                  $display("%0t: result %0d pixel_out expected %h got %h",
                           $time, pixels_checked, oldest.pixel, rsp_pixel_out);
                  mismatches++;
               end
               if (rsp_covered !== oldest.covered) begin
                  $display("%0t: result %0d covered expected %b got %b",
                           $time, pixels_checked, oldest.covered, rsp_covered);
                  mismatches++;
               end
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// ===== sim/shape_coverage_alpha_blend_tb.sv =====
module shape_coverage_alpha_blend_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]  mode;
      int          ox, oy, ew, eh, thick;
      logic [31:0] color;
   } shape_setting_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [11:0] req_pixel_x;
   logic [11:0] req_pixel_y;
   logic [31:0] req_dest_pixel;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_pixel_out;
   logic        rsp_covered;

   int mismatches, pending, pixels_checked, pixels_covered;
   int items_sent   = 0;
   int settings_run = 0;
   int stall_left   = 0;
   bit calm         = 0;   // no idling on either side
   bit squeeze      = 0;   // receiver holds off for a long stretch
   bit hold_done    = 0;   // long hold-off already taken

   localparam int HOLD_CYCLES = 400;

   shape_coverage_alpha_blend dut (.*);

   shape_coverage_alpha_blend_check checker_i (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .req_valid, .req_ready, .req_pixel_x, .req_pixel_y, .req_dest_pixel,
      .rsp_valid, .rsp_ready, .rsp_pixel_out, .rsp_covered,
      .mismatches, .pending, .pixels_checked, .pixels_covered
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly back-to-back, sometimes a few cycles, rarely a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int extreme13();
      case ($urandom_range(0, 3))
         0:       return -4096;
         1:       return 4095;
         2:       return -1;
         default: return 0;
      endcase
   endfunction

   // Coordinate near the shape most of the time, anywhere in the buffer otherwise
   function automatic logic [11:0] pick_coord(int center, int span);
      int v;
      if ($urandom_range(0, 9) < 3) return 12'($urandom_range(0, 4095));
      v = center - span + int'($urandom_range(0, 2 * span));
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return 12'(v);
   endfunction

   function automatic shape_setting_type make_shape(logic [1:0] mode, int ox, int oy, int ew,
                                                    int eh, int thick, logic [31:0] color);
      shape_setting_type s;
      s.mode  = mode;
      s.ox    = ox;
      s.oy    = oy;
      s.ew    = ew;
      s.eh    = eh;
      s.thick = thick;
      s.color = color;
      return s;
   endfunction

   // Registers change only with the pipeline drained
   task automatic program_shape(input shape_setting_type s);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = scab_pkg::CSR_SHAPE_MODE;
      csr_wdata = 32'(s.mode);
      @(negedge clock);
      csr_addr  = scab_pkg::CSR_ORIGIN_X;
      csr_wdata = 32'(s.ox);
      @(negedge clock);
      csr_addr  = scab_pkg::CSR_ORIGIN_Y;
      csr_wdata = 32'(s.oy);
      @(negedge clock);
      csr_addr  = scab_pkg::CSR_EXTENT_W;
      csr_wdata = 32'(s.ew);
      @(negedge clock);
      csr_addr  = scab_pkg::CSR_EXTENT_H;
      csr_wdata = 32'(s.eh);
      @(negedge clock);
      csr_addr  = scab_pkg::CSR_STROKE;
      csr_wdata = 32'(s.thick);
      @(negedge clock);
      csr_addr  = scab_pkg::CSR_DRAW_COLOR;
      csr_wdata = s.color;
      @(negedge clock);
      csr_we    = 1'b0;
      settings_run++;
   endtask

   // One input transaction, preceded by a random gap
   task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input logic [31:0] d);
      int gap;
      gap = calm ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid      = 1'b1;
      req_pixel_x    = x;
      req_pixel_y    = y;
      req_dest_pixel = d;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Result side back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze && !hold_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1;
         end
         if (calm) begin
            rsp_ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Stimulus
   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_addr       = scab_pkg::CSR_SHAPE_MODE;
      csr_wdata      = 32'h0;
      req_valid      = 1'b0;
      req_pixel_x    = 12'h0;
      req_pixel_y    = 12'h0;
      req_dest_pixel = 32'h0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset defaults: zero-size rectangle covers nothing
      send_pixel(12'd0, 12'd0, 32'h0000_0000);
      send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);

      // negative width normalized, opaque color replaces
      program_shape(make_shape(scab_pkg::MODE_RECT_FILL, 10, 20, -5, 3, 1, 32'hFF11_2233));
      send_pixel(12'd5, 12'd20, 32'h1234_5678);
      send_pixel(12'd9, 12'd22, 32'h8765_4321);
      send_pixel(12'd10, 12'd20, 32'hDEAD_BEEF);
      send_pixel(12'd4, 12'd20, 32'hCAFE_F00D);

      // negative height normalized
      program_shape(make_shape(scab_pkg::MODE_RECT_FILL, 50, 50, 4, -4, 1, 32'hFF00_FF00));
      send_pixel(12'd50, 12'd46, 32'h0102_0304);
      send_pixel(12'd50, 12'd50, 32'h0506_0708);

      // outline with zero thickness draws nothing
      program_shape(make_shape(scab_pkg::MODE_RECT_OUTLINE, 0, 0, 10, 10, 0, 32'h80A0_B0C0));
      send_pixel(12'd0, 12'd0, 32'h4455_6677);

      // outline, transparent color keeps the pixel
      program_shape(make_shape(scab_pkg::MODE_RECT_OUTLINE, 0, 0, 10, 10, 2, 32'h0044_5566));
      send_pixel(12'd0, 12'd0, 32'hA1B2_C3D4);
      send_pixel(12'd5, 12'd5, 32'hA1B2_C3D4);
      send_pixel(12'd9, 12'd9, 32'hA1B2_C3D4);

      // thickness swallows the inner rectangle
      program_shape(make_shape(scab_pkg::MODE_RECT_OUTLINE, 0, 0, 10, 10, 6, 32'h7F12_3456));
      send_pixel(12'd5, 12'd5, 32'hFEDC_BA98);

      // filled circle, half alpha
      program_shape(make_shape(scab_pkg::MODE_CIRCLE_FILL, 100, 100, 10, 0, 1, 32'h80FF_00FF));
      send_pixel(12'd110, 12'd100, 32'h2040_6080);
      send_pixel(12'd111, 12'd100, 32'h2040_6080);
      send_pixel(12'd100, 12'd100, 32'hFFFF_FFFF);

      // negative radius
      program_shape(make_shape(scab_pkg::MODE_CIRCLE_FILL, 100, 100, -3, 0, 1, 32'hFF00_0000));
      send_pixel(12'd100, 12'd100, 32'h1111_1111);

      // ring with zero thickness: outer edge only
      program_shape(make_shape(scab_pkg::MODE_CIRCLE_RING, 100, 100, 10, 0, 0, 32'h01FF_FFFF));
      send_pixel(12'd110, 12'd100, 32'h0000_0000);
      send_pixel(12'd109, 12'd100, 32'h0000_0000);

      // ring thicker than twice the radius is empty
      program_shape(make_shape(scab_pkg::MODE_CIRCLE_RING, 100, 100, 10, 0, 30, 32'hFE80_8080));
      send_pixel(12'd110, 12'd100, 32'h7777_7777);

      // random shapes, every sixth one built from extremes
      for (int p = 0; p < 32; p++) begin
         shape_setting_type s;
         int span, pick;
         s.mode = 2'($urandom_range(0, 3));
         if (p % 6 == 0) begin
            s.ox    = extreme13();
            s.oy    = extreme13();
            s.ew    = extreme13();
            s.eh    = extreme13();
            s.thick = ($urandom_range(0, 1) == 1) ? 4095 : int'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0:       s.color = 32'h0000_0000;
               1:       s.color = 32'hFFFF_FFFF;
               2:       s.color = 32'h00FF_FFFF;
               default: s.color = 32'hFF00_0000;
            endcase
         end else begin
            s.ox    = int'($urandom_range(0, 600)) - 100;
            s.oy    = int'($urandom_range(0, 600)) - 100;
            s.ew    = int'($urandom_range(0, 160)) - 80;
            s.eh    = int'($urandom_range(0, 160)) - 80;
            s.thick = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4095))
                                                  : int'($urandom_range(0, 10));
            s.color = $urandom;
            pick    = $urandom_range(0, 19);
            if (pick < 5) s.color[31:24] = 8'hFF;
            else if (pick < 9) s.color[31:24] = 8'h00;
         end
         program_shape(s);
         calm = (p == 5 || p == 10 || p == 20);
         // block fills while the receiver holds off
         if (p == 10) squeeze = 1;
         span = (s.ew < 0 ? -s.ew : s.ew) + (s.eh < 0 ? -s.eh : s.eh) + 4;
         repeat (38) send_pixel(pick_coord(s.ox, span), pick_coord(s.oy, span), $urandom);
      end

      // drain
      @(negedge clock);
      req_valid = 1'b0;
      calm = 0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d pixels across %0d shape settings (all four modes, extremes, a %0d-cycle",
               items_sent, settings_run, HOLD_CYCLES);
      $display("output hold-off); %0d results checked, %0d of them covered by the shape.",
               pixels_checked, pixels_covered);
      if (mismatches == 0) begin
         $display("[shape_coverage_alpha_blend] OK");
      end else begin
         $display("[shape_coverage_alpha_blend] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("[shape_coverage_alpha_blend] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/scab_pkg.sv
rtl/core/shape_coverage_alpha_blend.sv
sim/shape_coverage_alpha_blend_check.sv
sim/shape_coverage_alpha_blend_tb.sv
